>>> sv/svp_pkg.sv
`timescale 1ns / 1ps

package svp_pkg;

    // opcodes of the input item
    localparam logic [1:0] OP_WRITE    = 2'd0;
    localparam logic [1:0] OP_NOTE_ON  = 2'd1;
    localparam logic [1:0] OP_NOTE_OFF = 2'd2;
    localparam logic [1:0] OP_TICK     = 2'd3;

    // input item
    typedef struct packed {
        logic [1:0]         opcode;
        logic [15:0]        address;
        logic signed [15:0] sample_value;
        logic [15:0]        patch_length;
        logic [15:0]        loop_start;
        logic [15:0]        loop_end;
        logic [23:0]        increment;
        logic [15:0]        amplitude;
        logic               loop_enable;
    } svp_in_t;

    // result item
    typedef struct packed {
        logic signed [15:0] sample_out;
        logic               voice_active;
    } svp_out_t;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic mem_write;
        logic ld_quot;
        logic ld_addr;
        logic rd_b;
        logic rd_c;
        logic ld_diff;
        logic ld_scale;
        logic commit;
        logic emit_idle;
    } svp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic active;
        logic out_free;
    } svp_status_t;

endpackage

>>> sv/svp_ram.sv
`timescale 1ns / 1ps

module svp_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 256,
    localparam int unsigned AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             en,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // single port, registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (en) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/svp_ctrl.sv
`timescale 1ns / 1ps

module svp_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            opcode,
    input  svp_pkg::svp_status_t  status,
    output svp_pkg::svp_cmd_t     cmd
);

    import svp_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WR,
        ST_QUOT,
        ST_ADDR,
        ST_RD_B,
        ST_RD_C,
        ST_DIFF,
        ST_SCALE,
        ST_FINISH,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_ready = (state_reg == ST_IDLE);

    // sequencing of one item
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    case (opcode)
                        OP_WRITE:    state_next = ST_WR;
                        OP_TICK:     state_next = status.active ? ST_QUOT : ST_EMIT;
                        OP_NOTE_ON:  state_next = ST_IDLE;
                        OP_NOTE_OFF: state_next = ST_IDLE;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_WR: begin
                cmd.mem_write = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_QUOT: begin
                cmd.ld_quot = 1'b1;
                state_next  = ST_ADDR;
            end
            ST_ADDR: begin
                cmd.ld_addr = 1'b1;
                state_next  = ST_RD_B;
            end
            ST_RD_B: begin
                cmd.rd_b   = 1'b1;
                state_next = ST_RD_C;
            end
            ST_RD_C: begin
                cmd.rd_c   = 1'b1;
                state_next = ST_DIFF;
            end
            ST_DIFF: begin
                cmd.ld_diff = 1'b1;
                state_next  = ST_SCALE;
            end
            ST_SCALE: begin
                cmd.ld_scale = 1'b1;
                state_next   = ST_FINISH;
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit_idle = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> sv/svp_datapath.sv
`timescale 1ns / 1ps

module svp_datapath #(
    parameter int unsigned SAMPLE_DEPTH = 65536,
    parameter int unsigned FRAC_BITS    = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  svp_pkg::svp_in_t     s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output svp_pkg::svp_out_t    m_item,
    input  svp_pkg::svp_cmd_t    cmd,
    output svp_pkg::svp_status_t status
);

    import svp_pkg::*;

    localparam int unsigned FB     = FRAC_BITS;
    localparam int unsigned AW     = $clog2(SAMPLE_DEPTH);
    localparam int unsigned BASE_W = 32 - FB;
    localparam int unsigned SUM_W  = (BASE_W > 16) ? BASE_W : 16;
    localparam int unsigned ABS_W  = ((SUM_W > AW) ? SUM_W : AW) + 1;
    localparam int unsigned RW     = (ABS_W > AW) ? ABS_W : AW;
    localparam int unsigned WA_W   = ((AW + 1) > 17) ? (AW + 1) : 17;
    localparam int unsigned CMP_W  = (33 > (16 + FB)) ? 33 : (16 + FB);
    localparam int unsigned V_W    = FB + 18;
    localparam int unsigned P_W    = V_W + 17;

    // floor(2^ABS_W / depth): quotient estimate is at most one short
    localparam logic [ABS_W-1:0] MOD_M   = ABS_W'((64'd1 << ABS_W) / SAMPLE_DEPTH);
    localparam logic [ABS_W:0]   DEPTH_V = (ABS_W + 1)'(SAMPLE_DEPTH);
    localparam logic [WA_W-1:0]  DEPTH_A = WA_W'(SAMPLE_DEPTH);

    localparam logic signed [P_W-1:0] ROUND_C = P_W'(1) <<< (FB + 14);
    localparam logic signed [P_W-1:0] SAT_HI  = P_W'(32'sd32767);
    localparam logic signed [P_W-1:0] SAT_LO  = P_W'(-32'sd32768);

    function automatic logic [31:0] sat_pos(input logic [CMP_W-1:0] p);
        if (|p[CMP_W-1:32]) begin
            return '1;
        end
        return p[31:0];
    endfunction

    // voice state
    logic [31:0] pos_reg;
    logic [15:0] offset_reg;
    logic [15:0] end_reg;
    logic [15:0] lstart_reg;
    logic [15:0] lend_reg;
    logic        active_reg;

    // per item work registers
    svp_in_t                 item_reg;
    logic [ABS_W-1:0]        abs_reg;
    logic [ABS_W-1:0]        q_reg;
    logic [AW-1:0]           addr_b_reg;
    logic [AW-1:0]           addr_c_reg;
    logic                    has_c_reg;
    logic signed [15:0]      b_reg;
    logic signed [V_W-1:0]   diff_reg;
    logic signed [P_W-1:0]   scale_reg;
    logic                    m_valid_reg;
    svp_out_t                m_item_reg;

    // memory port
    logic [AW-1:0] mem_addr;
    logic [15:0]   mem_rdata;
    logic          mem_en;
    logic          mem_we;
    logic [WA_W-1:0] wr_addr_w;

    assign wr_addr_w = WA_W'(item_reg.address);
    assign mem_we    = cmd.mem_write && (wr_addr_w < DEPTH_A);
    assign mem_en    = cmd.rd_b || cmd.rd_c;

    always_comb begin
        if (cmd.rd_c) begin
            mem_addr = addr_c_reg;
        end else if (cmd.rd_b) begin
            mem_addr = addr_b_reg;
        end else begin
            mem_addr = wr_addr_w[AW-1:0];
        end
    end

    svp_ram #(
        .WIDTH (16),
        .DEPTH (SAMPLE_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (item_reg.sample_value),
        .rdata (mem_rdata)
    );

    // absolute address of the current sample
    logic [ABS_W-1:0] abs_next;
    assign abs_next = ABS_W'(offset_reg) + ABS_W'(pos_reg[31:FB]);

    // reduce the absolute address modulo the memory depth
    logic [2*ABS_W-1:0] quot_prod;
    logic [2*ABS_W:0]   back_prod;
    logic [ABS_W-1:0]   rem_raw;
    logic [ABS_W-1:0]   rem_fix;
    logic [RW-1:0]      rem_wide;
    logic [ABS_W:0]     abs_p1;
    logic [RW:0]        abs_p1_wide;

    assign quot_prod   = abs_reg * MOD_M;
    assign back_prod   = q_reg * DEPTH_V;
    assign rem_raw     = abs_reg - back_prod[ABS_W-1:0];
    assign rem_fix     = ({1'b0, rem_raw} >= DEPTH_V) ? (rem_raw - DEPTH_V[ABS_W-1:0])
                                                      : rem_raw;
    assign rem_wide    = RW'(rem_fix);
    assign abs_p1      = {1'b0, abs_reg} + (ABS_W + 1)'(1);
    assign abs_p1_wide = (RW + 1)'(abs_p1);

    // interpolation and gain
    logic signed [16:0]     diff_val;
    logic signed [FB:0]     frac_s;
    logic signed [V_W-1:0]  diff_prod;
    logic signed [V_W-1:0]  b_ext;
    logic signed [V_W-1:0]  v_val;
    logic signed [16:0]     amp_s;
    logic signed [P_W-1:0]  rounded;
    logic signed [P_W-1:0]  shifted;
    logic signed [15:0]     sat_val;

    assign diff_val  = (has_c_reg ? 17'(signed'(mem_rdata)) : 17'(b_reg)) - 17'(b_reg);
    assign frac_s    = signed'({1'b0, pos_reg[FB-1:0]});
    assign diff_prod = diff_val * frac_s;
    assign b_ext     = V_W'(b_reg) <<< FB;
    assign v_val     = b_ext + diff_reg;
    assign amp_s     = signed'({1'b0, item_reg.amplitude});
    assign rounded   = scale_reg + ROUND_C;
    assign shifted   = rounded >>> (FB + 15);

    always_comb begin
        if (shifted > SAT_HI) begin
            sat_val = 16'sd32767;
        end else if (shifted < SAT_LO) begin
            sat_val = -16'sd32768;
        end else begin
            sat_val = shifted[15:0];
        end
    end

    // position advance, loop wrap and end detection
    logic [CMP_W-1:0] next_w;
    logic [CMP_W-1:0] end_sh;
    logic [CMP_W-1:0] lend_sh;
    logic [CMP_W-1:0] lstart_sh;
    logic             end_hit;
    logic [31:0]      pos_upd;

    assign next_w    = CMP_W'(pos_reg) + CMP_W'(item_reg.increment);
    assign end_sh    = CMP_W'(end_reg) << FB;
    assign lend_sh   = CMP_W'(lend_reg) << FB;
    assign lstart_sh = CMP_W'(lstart_reg) << FB;
    assign end_hit   = (next_w >= end_sh);

    always_comb begin
        if (!end_hit && item_reg.loop_enable && (next_w > lend_sh)) begin
            pos_upd = sat_pos(lstart_sh);
        end else begin
            pos_upd = sat_pos(next_w);
        end
    end

    // note off target position
    logic [CMP_W-1:0] s_end_sh;
    assign s_end_sh = CMP_W'(end_reg) << FB;

    // voice state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            offset_reg  <= '0;
            end_reg     <= '0;
            lstart_reg  <= '0;
            lend_reg    <= '0;
            active_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.capture) begin
                case (s_item.opcode)
                    OP_NOTE_ON: begin
                        offset_reg <= s_item.address;
                        end_reg    <= s_item.patch_length;
                        lstart_reg <= s_item.loop_start;
                        lend_reg   <= s_item.loop_end;
                        pos_reg    <= '0;
                        active_reg <= 1'b1;
                    end
                    OP_NOTE_OFF: begin
                        if (s_item.loop_enable) begin
                            lend_reg <= end_reg;
                        end else begin
                            pos_reg <= sat_pos(s_end_sh);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (cmd.commit) begin
                pos_reg <= pos_upd;
                if (end_hit) begin
                    active_reg <= 1'b0;
                end
            end
            if (cmd.commit || cmd.emit_idle) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // work registers, no reset needed
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_reg <= s_item;
            abs_reg  <= abs_next;
        end
        if (cmd.ld_quot) begin
            q_reg <= quot_prod[2*ABS_W-1:ABS_W];
        end
        if (cmd.ld_addr) begin
            addr_b_reg <= rem_wide[AW-1:0];
            addr_c_reg <= abs_p1_wide[AW-1:0];
            has_c_reg  <= (abs_p1 < DEPTH_V);
        end
        if (cmd.rd_c) begin
            b_reg <= mem_rdata;
        end
        if (cmd.ld_diff) begin
            diff_reg <= diff_prod;
        end
        if (cmd.ld_scale) begin
            scale_reg <= v_val * amp_s;
        end
        if (cmd.commit) begin
            m_item_reg.sample_out   <= end_hit ? 16'sd0 : sat_val;
            m_item_reg.voice_active <= !end_hit;
        end else if (cmd.emit_idle) begin
            m_item_reg.sample_out   <= 16'sd0;
            m_item_reg.voice_active <= 1'b0;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_item          = m_item_reg;
    assign status.active   = active_reg;
    assign status.out_free = !m_valid_reg || m_ready;

endmodule

>>> sv/sample_playback_voice.sv
// one sampler voice with linear interpolation over a single-port sample memory
// tick: the sequencer steps through quotient, address, two reads of the single memory port
// and two multiply steps, then loads the result register; no new item is taken until then
// an idle tick passes the emit state, a sample write the write state, note on and off neither;
// only ticks give a result, and a result not yet taken holds the next one back
// synchronous active-low aresetn: voice off, position and patch bounds cleared, memory kept
`timescale 1ns / 1ps

module sample_playback_voice #(
    parameter int unsigned SAMPLE_DEPTH = 65536,
    parameter int unsigned FRAC_BITS    = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  svp_pkg::svp_in_t  s_item,
    output logic              m_valid,
    input  logic              m_ready,
    output svp_pkg::svp_out_t m_item
);

    import svp_pkg::*;

    svp_cmd_t    cmd;
    svp_status_t status;

    // sequencer
    svp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .opcode  (s_item.opcode),
        .status  (status),
        .cmd     (cmd)
    );

    // voice state, memory and arithmetic
    svp_datapath #(
        .SAMPLE_DEPTH (SAMPLE_DEPTH),
        .FRAC_BITS    (FRAC_BITS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item),
        .cmd     (cmd),
        .status  (status)
    );

endmodule

>>> test/tb_sample_playback_voice.sv
`timescale 1ns / 1ps

module tb_sample_playback_voice;
    import svp_pkg::*;

    localparam int ITEM_TARGET   = 1200;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 24;

    // row kinds of the directed table
    localparam bit PRED  = 1'b0;
    localparam bit FIXED = 1'b1;

    typedef struct {
        svp_in_t  item;
        bit       fixed;
        svp_out_t result;
    } dir_row_t;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    svp_in_t  s_item  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    svp_out_t m_item;

    // voice state as the block should hold it
    logic signed [15:0] voice_mem [65536];
    bit                 mem_written [65536];
    logic [31:0]        pv_pos        = '0;
    logic [15:0]        pv_offset     = '0;
    logic [15:0]        pv_end        = '0;
    logic [15:0]        pv_loop_start = '0;
    logic [15:0]        pv_loop_end   = '0;
    bit                 pv_active     = 1'b0;

    svp_out_t    expected_samples [$];
    dir_row_t    dir_table [$];
    int          error_count = 0;
    int          sent_count  = 0;
    int          burst_left  = 0;
    int          cycle_count = 0;
    logic [11:0] stall_phase = '0;

    sample_playback_voice dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always #2 aclk = ~aclk;

    // every field random, opcode included
    function automatic svp_in_t random_item();
        logic [127:0] raw;
        svp_in_t      it;
        raw = {$urandom(), $urandom(), $urandom(), $urandom()};
        it  = raw[$bits(svp_in_t)-1:0];
        return it;
    endfunction

    function automatic dir_row_t dir_row(input logic [1:0] op, input logic [15:0] addr,
            input logic [15:0] sval, input logic [15:0] len, input logic [15:0] ls,
            input logic [15:0] le, input logic [23:0] inc, input logic [15:0] amp,
            input logic lp, input bit fixed, input logic [15:0] want_sample,
            input logic want_active);
        dir_row_t r;
        r.item.opcode              = op;
        r.item.address             = addr;
        r.item.sample_value        = sval;
        r.item.patch_length        = len;
        r.item.loop_start          = ls;
        r.item.loop_end            = le;
        r.item.increment           = inc;
        r.item.amplitude           = amp;
        r.item.loop_enable         = lp;
        r.fixed                    = fixed;
        r.result.sample_out        = want_sample;
        r.result.voice_active      = want_active;
        return r;
    endfunction

    // advance the voice by one transfer and queue the sample a tick produces
    task automatic voice_predict(input svp_in_t it, input bit fixed, input svp_out_t want);
        logic [16:0] abs_addr;
        logic [32:0] next_pos;
        longint      b, c, v, r;
        svp_out_t    res;
        res = '0;
        case (it.opcode)
            OP_WRITE: begin
                voice_mem[it.address]   = it.sample_value;
                mem_written[it.address] = 1'b1;
            end
            OP_NOTE_ON: begin
                pv_offset     = it.address;
                pv_end        = it.patch_length;
                pv_loop_start = it.loop_start;
                pv_loop_end   = it.loop_end;
                pv_pos        = '0;
                pv_active     = 1'b1;
            end
            OP_NOTE_OFF: begin
                if (it.loop_enable) begin
                    pv_loop_end = pv_end;
                end else begin
                    pv_pos = {pv_end, 16'h0000};
                end
            end
            default: begin
                if (pv_active) begin
                    // interpolate between the sample and its upper neighbor
                    abs_addr = {1'b0, pv_offset} + {1'b0, pv_pos[31:16]};
                    b = longint'(voice_mem[abs_addr[15:0]]);
                    if (abs_addr < 17'd65535) begin
                        c = longint'(voice_mem[abs_addr[15:0] + 16'd1]);
                    end else begin
                        c = b;
                    end
                    v = b * 65536 + (c - b) * longint'(pv_pos[15:0]);
                    // scale, round half up, saturate
                    r = (v * longint'(it.amplitude) + (longint'(1) <<< 30)) >>> 31;
                    if (r > 32767) begin
                        r = 32767;
                    end else if (r < -32768) begin
                        r = -32768;
                    end
                    // step, end of patch, loop wrap
                    next_pos = {1'b0, pv_pos} + {9'd0, it.increment};
                    if (next_pos >= {1'b0, pv_end, 16'h0000}) begin
                        pv_active = 1'b0;
                        r = 0;
                    end else if (it.loop_enable && next_pos > {1'b0, pv_loop_end, 16'h0000}) begin
                        next_pos = {1'b0, pv_loop_start, 16'h0000};
                    end
                    pv_pos = next_pos[32] ? 32'hFFFF_FFFF : next_pos[31:0];
                    res.sample_out   = r[15:0];
                    res.voice_active = pv_active;
                end
                expected_samples.push_back(fixed ? want : res);
            end
        endcase
    endtask

    // drive one transfer in bursts with random gaps, then predict on acceptance
    task automatic push_item(input svp_in_t it, input bit fixed, input svp_out_t want);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 8);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? 64 : $urandom_range(1, 12);
        end
        s_item  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
        sent_count++;
        voice_predict(it, fixed, want);
    endtask

    // a tick only reads memory that was written before
    task automatic issue(input svp_in_t it, input bit fixed, input svp_out_t want);
        logic [16:0] abs_addr;
        logic [15:0] rd_addr;
        svp_in_t     fill;
        if (it.opcode == OP_TICK && pv_active) begin
            abs_addr = {1'b0, pv_offset} + {1'b0, pv_pos[31:16]};
            for (int k = 0; k < 2; k++) begin
                rd_addr = abs_addr[15:0] + 16'(k);
                if ((k == 0 || abs_addr < 17'd65535) && !mem_written[rd_addr]) begin
                    fill         = random_item();
                    fill.opcode  = OP_WRITE;
                    fill.address = rd_addr;
                    push_item(fill, PRED, '0);
                end
            end
        end
        push_item(it, fixed, want);
    endtask

    // receiver stalls, the pattern set by stall_phase[9:8]
    always @(posedge aclk) begin
        stall_phase <= stall_phase + 12'd1;
        case (stall_phase[9:8])
            2'd0: m_ready <= 1'b1;
            2'd1: m_ready <= 1'($urandom_range(0, 1));
            2'd2: m_ready <= (stall_phase[3:0] == 4'd0);
            default: m_ready <= stall_phase[2];
        endcase
    end

    // compare each result transfer with the oldest expected sample
    always @(posedge aclk) begin : check_results
        svp_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_samples.size() == 0) begin
                $error("result with nothing pending: sample_out %0d voice_active %0d",
                       m_item.sample_out, m_item.voice_active);
                error_count++;
            end else begin
                want = expected_samples.pop_front();
                if (m_item.sample_out !== want.sample_out) begin
                    $error("sample_out: expected %0d, got %0d",
                           want.sample_out, m_item.sample_out);
                    error_count++;
                end
                if (m_item.voice_active !== want.voice_active) begin
                    $error("voice_active: expected %0d, got %0d",
                           want.voice_active, m_item.voice_active);
                    error_count++;
                end
            end
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_sample_playback_voice: errors");
            $finish;
        end
    end

    initial begin
        svp_in_t     it;
        int          pick;
        int          run;
        int          off_at;
        logic [23:0] step;
        logic        lp;
        bit          drained;
        drained = 1'b0;

        // directed table: idle tick, extremes, wrap at the top of memory,
        // zero length, loop start past the end, both kinds of note off
        dir_table.push_back(dir_row(OP_TICK, 0, 0, 0, 0, 0, 'h0, 'hFFFF, 1, FIXED, 0, 0));
        dir_table.push_back(dir_row(OP_WRITE, 0, 32767, 0, 0, 0, 0, 0, 0, PRED, 0, 0));
        dir_table.push_back(dir_row(OP_WRITE, 1, -32768, 0, 0, 0, 0, 0, 0, PRED, 0, 0));
        dir_table.push_back(dir_row(OP_WRITE, 2, 0, 0, 0, 0, 0, 0, 0, PRED, 0, 0));
        dir_table.push_back(dir_row(OP_WRITE, 3, 1000, 0, 0, 0, 0, 0, 0, PRED, 0, 0));
        dir_table.push_back(dir_row(OP_WRITE, 'hFFFF, 'h1234, 0, 0, 0, 0, 0, 0, PRED, 0, 0));
        // half-sample steps across a full-scale edge
        dir_table.push_back(dir_row(OP_NOTE_ON, 0, 0, 2, 0, 1, 0, 0, 0, PRED, 0, 0));
        dir_table.push_back(dir_row(OP_TICK, 0, 0, 0, 0, 0, 'h8000, 'h8000, 0,
                                    FIXED, 32767, 1));
        dir_table.push_back(dir_row(OP_TICK, 0, 0, 0, 0, 0, 'h8000, 'hFFFF, 0, PRED, 0, 0));
        dir_table.push_back(dir_row(OP_TICK, 0, 0, 0, 0, 0, 'h8000, 'hFFFF, 0,
                                    FIXED, -32768, 1));
        dir_table.push_back(dir_row(OP_TICK, 0, 0, 0, 0, 0, 'h8000, 'hFFFF, 0, FIXED, 0, 0));
        // zero length ends on the first tick
        dir_table.push_back(dir_row(OP_NOTE_ON, 'hFFFF, 0, 0, 'hFFFF, 'hFFFF, 0, 0, 0,
                                    PRED, 0, 0));
        dir_table.push_back(dir_row(OP_TICK, 0, 0, 0, 0, 0, 'hFFFFFF, 'hFFFF, 1,
                                    FIXED, 0, 0));
        // last address has no neighbor, position runs past the top
        dir_table.push_back(dir_row(OP_NOTE_ON, 'hFFFF, 0, 'hFFFF, 0, 0, 0, 0, 0,
                                    PRED, 0, 0));
        dir_table.push_back(dir_row(OP_TICK, 0, 0, 0, 0, 0, 'hFFFFFF, 'hFFFF, 0, PRED, 0, 0));
        dir_table.push_back(dir_row(OP_NOTE_OFF, 0, 0, 0, 0, 0, 0, 0, 0, PRED, 0, 0));
        dir_table.push_back(dir_row(OP_TICK, 0, 0, 0, 0, 0, 0, 'hFFFF, 0, FIXED, 0, 0));
        // loop start beyond the end, address wraps to zero
        dir_table.push_back(dir_row(OP_NOTE_ON, 1, 0, 4, 'hFFFF, 0, 0, 0, 0, PRED, 0, 0));
        dir_table.push_back(dir_row(OP_TICK, 0, 0, 0, 0, 0, 'h10000, 'h8000, 1, PRED, 0, 0));
        dir_table.push_back(dir_row(OP_TICK, 0, 0, 0, 0, 0, 'h10000, 'h8000, 1, FIXED, 0, 0));
        // loop wrap, release of the loop, then jump to the end
        dir_table.push_back(dir_row(OP_NOTE_ON, 0, 0, 3, 0, 1, 0, 0, 0, PRED, 0, 0));
        dir_table.push_back(dir_row(OP_TICK, 0, 0, 0, 0, 0, 'h18000, 40000, 1, PRED, 0, 0));
        dir_table.push_back(dir_row(OP_NOTE_OFF, 0, 0, 0, 0, 0, 0, 0, 1, PRED, 0, 0));
        dir_table.push_back(dir_row(OP_TICK, 0, 0, 0, 0, 0, 'h18000, 40000, 1, PRED, 0, 0));
        dir_table.push_back(dir_row(OP_NOTE_OFF, 0, 0, 0, 0, 0, 0, 0, 0, PRED, 0, 0));
        dir_table.push_back(dir_row(OP_TICK, 0, 0, 0, 0, 0, 'h18000, 40000, 0, FIXED, 0, 0));

        // reset
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_table[i]) begin
            issue(dir_table[i].item, dir_table[i].fixed, dir_table[i].result);
        end

        // random notes, mostly well-formed note on plus tick runs
        while (sent_count < ITEM_TARGET) begin
            // hold off once until the output side has caught up
            if (!drained && sent_count >= ITEM_TARGET / 2) begin
                s_valid <= 1'b0;
                do @(posedge aclk); while (expected_samples.size() != 0);
                drained = 1'b1;
            end
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                it        = random_item();
                it.opcode = OP_NOTE_ON;
                if ($urandom_range(0, 4) != 0) begin
                    it.patch_length = 16'($urandom_range(0, 48));
                    it.loop_start   = 16'($urandom_range(0, it.patch_length + 2));
                    it.loop_end     = 16'($urandom_range(it.loop_start, it.patch_length + 4));
                end
                issue(it, PRED, '0);
                case ($urandom_range(0, 3))
                    0: step = 24'($urandom_range(0, 24'h00FFFF));
                    1: step = 24'($urandom_range(24'h008000, 24'h030000));
                    2: step = 24'($urandom());
                    default: step = 24'h010000;
                endcase
                lp     = 1'($urandom_range(0, 1));
                run    = $urandom_range(1, 30);
                off_at = -1;
                if ($urandom_range(0, 3) == 0) begin
                    off_at = $urandom_range(0, run - 1);
                end
                for (int t = 0; t < run; t++) begin
                    if (t == off_at) begin
                        it        = random_item();
                        it.opcode = OP_NOTE_OFF;
                        issue(it, PRED, '0);
                    end
                    it             = random_item();
                    it.opcode      = OP_TICK;
                    it.increment   = step;
                    it.loop_enable = ($urandom_range(0, 9) == 0) ? !lp : lp;
                    if ($urandom_range(0, 7) == 0) begin
                        case ($urandom_range(0, 2))
                            0: it.amplitude = 16'h0000;
                            1: it.amplitude = 16'h8000;
                            default: it.amplitude = 16'hFFFF;
                        endcase
                    end
                    issue(it, PRED, '0);
                end
            end else if (pick == 7) begin
                repeat ($urandom_range(1, 4)) begin
                    it        = random_item();
                    it.opcode = OP_WRITE;
                    issue(it, PRED, '0);
                end
            end else begin
                issue(random_item(), PRED, '0);
            end
        end

        // drain and let stray results show up
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_samples.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("tb_sample_playback_voice: clean");
        end else begin
            $display("tb_sample_playback_voice: errors");
        end
        $finish;
    end

endmodule
